// ----- hw/rtl/nva_pkg.sv -----
// nva_pkg: sizes, codes and shared types of the note voice allocator
// used by the controller, the datapath and the top level; no dependencies

package nva_pkg;

   localparam int MAX_VOICES      = 16;
   localparam int VOICES_PER_LANE = 4;
   localparam int MAX_RESULTS     = 16;

   localparam int IDX_W  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int LANE_W = (VOICES_PER_LANE > 1) ? $clog2(VOICES_PER_LANE) : 1;
   localparam int EVC_W  = $clog2(MAX_RESULTS + 1);

   localparam logic [4:0] CH_MIN  = 5'd1;
   localparam logic [4:0] CH_MAX  = 5'd16;
   localparam logic [6:0] VEL_MIN = 7'd1;
   localparam logic [6:0] VEL_MAX = 7'd127;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_RETIRE  = 2'd3
   } cmd_type;

   typedef enum logic {
      REG_VOICE_LIMIT = 1'b0,
      REG_POLY_MODE   = 1'b1
   } reg_type;

   typedef enum logic {
      EV_NOTE_OFF = 1'b0,
      EV_NOTE_ON  = 1'b1
   } ev_kind_type;

   typedef struct packed {
      logic load;
      logic sweep_step;
      logic search_step;
      logic steal;
      logic noteon;
      logic flush;
   } ctl_cmd_type;

   typedef struct packed {
      logic req_is_start;
      logic can_emit;
      logic out_free;
      logic sweep_done;
      logic search_done;
   } dp_status_type;

endpackage

// ----- hw/rtl/note_voice_allocator_unit.sv -----
// note_voice_allocator_unit: top level of the note voice allocator
// depends on nva_pkg, nva_ctrl and nva_datapath

// Polyphonic voice allocator with voice stealing over a table of MAX_VOICES
// slots. One request word is taken at a time; the slot table is walked one
// slot per cycle through a single read and write port. Tick, release-all and
// retire-unowned run load, sweep and flush; start note runs load, search,
// steal, note-on and flush, with the search over the clamped slot range.
// Response stalls hold sweep, steal, note-on and flush once one event waits
// in the staging register and one in the output register. Each event is one
// response word; the final one of a request carries last. Configuration must
// be written over the APB port only while no request is in flight, which the
// block does not enforce; pready is tied high. No clearing pass after reset.

module note_voice_allocator_unit
   import nva_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic [6:0]  req_note,
   input  logic [4:0]  req_channel,
   input  logic [6:0]  req_velocity,
   input  logic [23:0] req_gate_samples,
   input  logic [3:0]  req_begin_slot,
   input  logic [4:0]  req_end_slot,
   input  logic [15:0] req_time_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_event_kind,
   output logic [6:0]  rsp_event_note,
   output logic [4:0]  rsp_event_channel,
   output logic [6:0]  rsp_event_velocity,
   output logic [3:0]  rsp_event_slot,
   output logic [15:0] rsp_event_offset,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign pready = 1'b1;

   nva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   nva_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_note           (req_note),
      .req_channel        (req_channel),
      .req_velocity       (req_velocity),
      .req_gate_samples   (req_gate_samples),
      .req_begin_slot     (req_begin_slot),
      .req_end_slot       (req_end_slot),
      .req_time_offset    (req_time_offset),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_event_note     (rsp_event_note),
      .rsp_event_channel  (rsp_event_channel),
      .rsp_event_velocity (rsp_event_velocity),
      .rsp_event_slot     (rsp_event_slot),
      .rsp_event_offset   (rsp_event_offset),
      .rsp_last           (rsp_last),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata)
   );

endmodule

// ----- hw/rtl/nva_ctrl.sv -----
// nva_ctrl: sequencing state machine of the note voice allocator
// depends on nva_pkg; drives the datapath through ctl_cmd_type

module nva_ctrl
   import nva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctl_cmd_type   cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SWEEP  = 6'b000010,
      S_SEARCH = 6'b000100,
      S_STEAL  = 6'b001000,
      S_NOTEON = 6'b010000,
      S_FLUSH  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.req_is_start ? S_SEARCH : S_SWEEP;
            end
         end
         S_SWEEP: begin
            if (status.can_emit) begin
               cmd.sweep_step = 1'b1;
               if (status.sweep_done) state_in = S_FLUSH;
            end
         end
         S_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.search_done) state_in = S_STEAL;
         end
         S_STEAL: begin
            if (status.can_emit) begin
               cmd.steal = 1'b1;
               state_in  = S_NOTEON;
            end
         end
         S_NOTEON: begin
            if (status.can_emit) begin
               cmd.noteon = 1'b1;
               state_in   = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- hw/rtl/nva_datapath.sv -----
// nva_datapath: voice slot table, search trackers, event staging and registers
// depends on nva_pkg; commanded by nva_ctrl

module nva_datapath
   import nva_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctl_cmd_type   cmd,
   output dp_status_type status,
   input  logic [1:0]    req_cmd,
   input  logic [6:0]    req_note,
   input  logic [4:0]    req_channel,
   input  logic [6:0]    req_velocity,
   input  logic [23:0]   req_gate_samples,
   input  logic [3:0]    req_begin_slot,
   input  logic [4:0]    req_end_slot,
   input  logic [15:0]   req_time_offset,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_event_kind,
   output logic [6:0]    rsp_event_note,
   output logic [4:0]    rsp_event_channel,
   output logic [6:0]    rsp_event_velocity,
   output logic [3:0]    rsp_event_slot,
   output logic [15:0]   rsp_event_offset,
   output logic          rsp_last,
   input  logic          psel,
   input  logic          penable,
   input  logic          pwrite,
   input  logic [2:0]    paddr,
   input  logic [31:0]   pwdata,
   output logic [31:0]   prdata
);

   typedef struct packed {
      logic       kind;
      logic [6:0] note;
      logic [4:0] chan;
      logic [6:0] vel;
      logic [3:0] slot;
   } ev_type;

   localparam logic [7:0] MAXM1_8 = 8'(MAX_VOICES - 1);
   localparam logic [7:0] MAX_8   = 8'(MAX_VOICES);
   localparam logic [7:0] VPL_8   = 8'(VOICES_PER_LANE);

   // slot table
   logic        slot_active_ff [MAX_VOICES];
   logic [6:0]  slot_note_ff   [MAX_VOICES];
   logic [3:0]  slot_chan_ff   [MAX_VOICES];
   logic [23:0] slot_rem_ff    [MAX_VOICES];

   // configuration
   logic [2:0] voice_limit_ff;
   logic       poly_ff;

   // latched word
   cmd_type          cmd_ff;
   logic [6:0]       note_ff;
   logic [4:0]       ch_ff;
   logic [3:0]       c0_ff;
   logic [6:0]       vel_ff;
   logic [23:0]      gate_ff;
   logic [IDX_W-1:0] first_ff;
   logic [IDX_W-1:0] last_idx_ff;
   logic [15:0]      offset_ff;

   // scan position and search trackers
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic              match_found_ff, match_found_in;
   logic [IDX_W-1:0]  match_idx_ff, match_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]  min_idx_ff, min_idx_in;
   logic [23:0]       min_rem_ff, min_rem_in;
   logic [6:0]        min_note_ff, min_note_in;
   logic [3:0]        min_chan_ff, min_chan_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;

   // event staging and output register
   logic             pend_valid_ff, pend_valid_in;
   ev_type           pend_ff, pend_in;
   logic [EVC_W-1:0] ev_count_ff, ev_count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ev_type           rsp_ev_ff, rsp_ev_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [15:0]      rsp_offset_ff, rsp_offset_in;

   // request clamps
   logic [4:0]  ld_ch;
   logic [7:0]  ld_first8;
   logic [7:0]  ld_end8;

   // slot read and write port
   logic        rd_active;
   logic [6:0]  rd_note;
   logic [3:0]  rd_chan;
   logic [23:0] rd_rem;
   logic        wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic        wr_active;
   logic [6:0]  wr_note;
   logic [3:0]  wr_chan;
   logic [23:0] wr_rem;

   logic        emit;
   ev_type      ev_new;
   logic [7:0]  lim8;
   logic        owned;
   logic [IDX_W-1:0] pick_sel;
   logic        cfg_wr;

   assign rd_active = slot_active_ff[idx_ff];
   assign rd_note   = slot_note_ff[idx_ff];
   assign rd_chan   = slot_chan_ff[idx_ff];
   assign rd_rem    = slot_rem_ff[idx_ff];

   always_comb begin
      ld_ch = req_channel;
      if (req_channel < CH_MIN)      ld_ch = CH_MIN;
      else if (req_channel > CH_MAX) ld_ch = CH_MAX;
      ld_first8 = 8'(req_begin_slot);
      if (ld_first8 > MAXM1_8) ld_first8 = MAXM1_8;
      ld_end8 = 8'(req_end_slot);
      if (ld_end8 < ld_first8 + 8'd1) ld_end8 = ld_first8 + 8'd1;
      if (ld_end8 > MAX_8)            ld_end8 = MAX_8;
   end

   always_comb begin
      lim8 = 8'(voice_limit_ff);
      if (lim8 < 8'd1)       lim8 = 8'd1;
      else if (lim8 > VPL_8) lim8 = VPL_8;
      owned = poly_ff ? (8'(lane_ff) < lim8) : (8'(idx_ff) < lim8);
   end

   always_comb begin
      if (match_found_ff)     pick_sel = match_idx_ff;
      else if (free_found_ff) pick_sel = free_idx_ff;
      else                    pick_sel = min_idx_ff;
   end

   // per-step slot update and event generation
   always_comb begin
      emit      = 1'b0;
      ev_new    = '0;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_active = rd_active;
      wr_note   = rd_note;
      wr_chan   = rd_chan;
      wr_rem    = rd_rem;
      if (cmd.sweep_step && rd_active) begin
         ev_new = '{kind: EV_NOTE_OFF, note: rd_note, chan: 5'(rd_chan) + 5'd1,
                    vel: 7'd0, slot: 4'(idx_ff)};
         unique case (cmd_ff)
            CMD_TICK: begin
               wr_en = 1'b1;
               if (rd_rem <= 24'd1) begin
                  emit      = 1'b1;
                  wr_active = 1'b0;
                  wr_rem    = 24'd0;
               end else begin
                  wr_rem = rd_rem - 24'd1;
               end
            end
            CMD_RELEASE: begin
               emit      = 1'b1;
               wr_en     = 1'b1;
               wr_active = 1'b0;
               wr_rem    = 24'd0;
            end
            CMD_RETIRE: begin
               if (!owned) begin
                  emit      = 1'b1;
                  wr_en     = 1'b1;
                  wr_active = 1'b0;
                  wr_rem    = 24'd0;
               end
            end
            CMD_START: ;
            default: ;
         endcase
      end
      if (cmd.steal) begin
         if (match_found_ff) begin
            emit   = 1'b1;
            ev_new = '{kind: EV_NOTE_OFF, note: note_ff, chan: ch_ff,
                       vel: 7'd0, slot: 4'(pick_sel)};
         end else if (!free_found_ff) begin
            emit   = 1'b1;
            ev_new = '{kind: EV_NOTE_OFF, note: min_note_ff,
                       chan: 5'(min_chan_ff) + 5'd1, vel: 7'd0, slot: 4'(pick_sel)};
         end
      end
      if (cmd.noteon) begin
         emit      = 1'b1;
         ev_new    = '{kind: EV_NOTE_ON, note: note_ff, chan: ch_ff,
                       vel: vel_ff, slot: 4'(pick_ff)};
         wr_en     = 1'b1;
         wr_addr   = pick_ff;
         wr_active = 1'b1;
         wr_note   = note_ff;
         wr_chan   = c0_ff;
         wr_rem    = gate_ff;
      end
   end

   // scan position and search trackers
   always_comb begin
      idx_in         = idx_ff;
      lane_in        = lane_ff;
      match_found_in = match_found_ff;
      match_idx_in   = match_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      min_idx_in     = min_idx_ff;
      min_rem_in     = min_rem_ff;
      min_note_in    = min_note_ff;
      min_chan_in    = min_chan_ff;
      pick_in        = pick_ff;
      if (cmd.load) begin
         idx_in         = (cmd_type'(req_cmd) == CMD_START) ? IDX_W'(ld_first8) : '0;
         lane_in        = '0;
         match_found_in = 1'b0;
         free_found_in  = 1'b0;
      end
      if (cmd.sweep_step || cmd.search_step) begin
         idx_in  = idx_ff + 1'b1;
         lane_in = (32'(lane_ff) == VOICES_PER_LANE - 1) ? '0 : lane_ff + 1'b1;
      end
      if (cmd.search_step) begin
         if (!match_found_ff && rd_active && rd_note == note_ff && rd_chan == c0_ff) begin
            match_found_in = 1'b1;
            match_idx_in   = idx_ff;
         end
         if (!free_found_ff && !rd_active) begin
            free_found_in = 1'b1;
            free_idx_in   = idx_ff;
         end
         if (idx_ff == first_ff || rd_rem < min_rem_ff) begin
            min_idx_in  = idx_ff;
            min_rem_in  = rd_rem;
            min_note_in = rd_note;
            min_chan_in = rd_chan;
         end
      end
      if (cmd.steal) pick_in = pick_sel;
   end

   // event staging: a new event pushes the staged one out as not last; flush sends it out as last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      ev_count_in   = ev_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_ev_in     = rsp_ev_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_offset_in = rsp_offset_ff;
      if (cmd.load) ev_count_in = '0;
      if (emit && ev_count_ff < EVC_W'(MAX_RESULTS)) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_ev_in     = pend_ff;
            rsp_last_in   = 1'b0;
            rsp_offset_in = offset_ff;
         end
         pend_valid_in = 1'b1;
         pend_in       = ev_new;
         ev_count_in   = ev_count_ff + 1'b1;
      end
      if (cmd.flush && pend_valid_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_ev_in     = pend_ff;
         rsp_last_in   = 1'b1;
         rsp_offset_in = offset_ff;
         pend_valid_in = 1'b0;
      end
   end

   always_comb begin
      status.req_is_start = (cmd_type'(req_cmd) == CMD_START);
      status.out_free     = !rsp_valid_ff || rsp_ready;
      status.can_emit     = !pend_valid_ff || !rsp_valid_ff || rsp_ready;
      status.sweep_done   = (32'(idx_ff) == MAX_VOICES - 1);
      status.search_done  = (idx_ff == last_idx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VOICES; i++) slot_active_ff[i] <= 1'b0;
      end else if (wr_en) begin
         slot_active_ff[wr_addr] <= wr_active;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_note_ff[wr_addr] <= wr_note;
         slot_chan_ff[wr_addr] <= wr_chan;
         slot_rem_ff[wr_addr]  <= wr_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff      <= cmd_type'(req_cmd);
         note_ff     <= req_note;
         ch_ff       <= ld_ch;
         c0_ff       <= 4'(ld_ch - 5'd1);
         vel_ff      <= (req_velocity < VEL_MIN) ? VEL_MIN :
                        (req_velocity > VEL_MAX) ? VEL_MAX : req_velocity;
         gate_ff     <= (req_gate_samples == 24'd0) ? 24'd1 : req_gate_samples;
         first_ff    <= IDX_W'(ld_first8);
         last_idx_ff <= IDX_W'(ld_end8 - 8'd1);
         offset_ff   <= req_time_offset;
      end
      idx_ff        <= idx_in;
      lane_ff       <= lane_in;
      match_idx_ff  <= match_idx_in;
      free_idx_ff   <= free_idx_in;
      min_idx_ff    <= min_idx_in;
      min_rem_ff    <= min_rem_in;
      min_note_ff   <= min_note_in;
      min_chan_ff   <= min_chan_in;
      pick_ff       <= pick_in;
      pend_ff       <= pend_in;
      rsp_ev_ff     <= rsp_ev_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         pend_valid_ff  <= 1'b0;
         ev_count_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         match_found_ff <= match_found_in;
         free_found_ff  <= free_found_in;
         pend_valid_ff  <= pend_valid_in;
         ev_count_ff    <= ev_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // configuration registers
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         voice_limit_ff <= 3'd1;
         poly_ff        <= 1'b0;
      end else if (cfg_wr) begin
         unique case (reg_type'(paddr[2]))
            REG_VOICE_LIMIT: voice_limit_ff <= pwdata[2:0];
            REG_POLY_MODE:   poly_ff        <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_type'(paddr[2]))
         REG_VOICE_LIMIT: prdata = 32'(voice_limit_ff);
         REG_POLY_MODE:   prdata = 32'(poly_ff);
         default:         prdata = '0;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_event_kind     = rsp_ev_ff.kind;
   assign rsp_event_note     = rsp_ev_ff.note;
   assign rsp_event_channel  = rsp_ev_ff.chan;
   assign rsp_event_velocity = rsp_ev_ff.vel;
   assign rsp_event_slot     = rsp_ev_ff.slot;
   assign rsp_event_offset   = rsp_offset_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ----- hw/rtl/nva_checker.sv -----
// nva_checker: port-level assertions for note_voice_allocator_unit
// depends on nva_pkg; attached to the top level by the bind below

module nva_checker
   import nva_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_event_kind,
   input logic [6:0] rsp_event_velocity,
   input logic       rsp_last
);

   // a stalled response word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped while stalled");

   // a note-on always closes the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_NOTE_ON |-> rsp_last)
      else $error("note-on not marked last");

   // note-off carries zero velocity, note-on never does
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_kind == EV_NOTE_OFF) == (rsp_event_velocity == 7'd0)))
      else $error("velocity does not match event kind");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind note_voice_allocator_unit nva_checker u_checker (.*);
